[rtl/core/sorted_table_insert_delete_top_assert.svh]
// Assertion macros for the sorted table block.
// Needs clk and rst_n to be visible where the macros are used.
`ifndef SORTED_TABLE_INSERT_DELETE_TOP_ASSERT_SVH
`define SORTED_TABLE_INSERT_DELETE_TOP_ASSERT_SVH

// checked outside reset
`define STI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define STI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/sti_pkg.sv]
// Package for the sorted table block: widths, codes, FSM state type.
// No dependencies.
`default_nettype none

package sti_pkg;

    localparam int unsigned STI_CAPACITY = 64;
    localparam int unsigned STI_DATA_W   = 32;
    localparam int unsigned STI_COUNT_W  = 7;
    localparam int unsigned STI_STATUS_W = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [STI_STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STI_STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STI_STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_RESULT
    } sti_state_t;

endpackage

`default_nettype wire

[rtl/core/sti_req_if.sv]
// Request channel: one operation word (op, value) with valid/ready.
// Depends on sti_pkg.
`default_nettype none

interface sti_req_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   op;
    logic signed [sti_pkg::STI_DATA_W-1:0]  value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

[rtl/core/sti_rsp_if.sv]
// Response channel: one result word (status, count, smallest, empty_res).
// Depends on sti_pkg.
`default_nettype none

interface sti_rsp_if;
    logic                                     valid;
    logic                                     ready;
    logic [sti_pkg::STI_STATUS_W-1:0]         status;
    logic [sti_pkg::STI_COUNT_W-1:0]          count;
    logic signed [sti_pkg::STI_DATA_W-1:0]    smallest;
    logic                                     empty_res;

    modport source (output valid, output status, output count, output smallest,
                    output empty_res, input ready);
    modport sink   (input valid, input status, input count, input smallest,
                    input empty_res, output ready);
endinterface

`default_nettype wire

[rtl/core/sorted_table_insert_delete_top.sv]
// Accept to result valid: a full insert goes straight to the result, an insert walks down from
// the top entry to its sorted slot, a delete walks every entry; plus any wait for the response slot.
// One word in flight; the next word is taken once the result is registered.
// Cost is set by the single table memory: each entry is read in ST_RD, then compared in ST_CMP.
// Reset clears the entry count and handshake state; table memory is not cleared.
// Sorted table top: FSM around one synchronous table memory.
// Depends on sti_pkg, sti_req_if, sti_rsp_if.
`default_nettype none

module sorted_table_insert_delete_top #(
    parameter int unsigned CAPACITY = sti_pkg::STI_CAPACITY
) (
    input  wire logic clk,
    input  wire logic rst_n,
    sti_req_if.sink   req,
    sti_rsp_if.source rsp
);
    import sti_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned AW    = $clog2(CAPACITY);
    localparam int unsigned EXT_W = (CNT_W > STI_COUNT_W) ? CNT_W : STI_COUNT_W;

    logic signed [STI_DATA_W-1:0] mem [CAPACITY];
    logic signed [STI_DATA_W-1:0] mem_rdata_reg;
    logic                         mem_we;
    logic                         mem_re;
    logic [AW-1:0]                mem_waddr;
    logic [AW-1:0]                mem_raddr;
    logic signed [STI_DATA_W-1:0] mem_wdata;

    sti_state_t                   state_reg, state_next;
    logic [CNT_W-1:0]             ptr_reg, ptr_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         op_reg, op_next;
    logic signed [STI_DATA_W-1:0] value_reg, value_next;
    logic                         found_reg, found_next;
    logic [STI_STATUS_W-1:0]      status_reg, status_next;
    logic signed [STI_DATA_W-1:0] smallest_reg, smallest_next;

    logic                         rsp_valid_reg, rsp_valid_next;
    logic [STI_STATUS_W-1:0]      rsp_status_reg, rsp_status_next;
    logic [STI_COUNT_W-1:0]       rsp_count_reg, rsp_count_next;
    logic signed [STI_DATA_W-1:0] rsp_smallest_reg, rsp_smallest_next;
    logic                         rsp_empty_reg, rsp_empty_next;

    logic                         req_fire;
    logic                         is_full;
    logic                         ins_at_end;
    logic                         del_at_end;
    logic                         rd_greater;
    logic                         rd_equal;
    logic                         rsp_free;
    logic [CNT_W-1:0]             ptr_dec;
    logic [EXT_W-1:0]             count_ext;

    assign req.ready      = (state_reg == ST_IDLE);
    assign req_fire       = req.valid && req.ready;
    assign is_full        = (count_reg == CNT_W'(CAPACITY));
    assign ins_at_end     = (ptr_reg == '0);
    assign del_at_end     = (ptr_reg == count_reg);
    assign rd_greater     = (mem_rdata_reg > value_reg);
    assign rd_equal       = (mem_rdata_reg == value_reg);
    assign rsp_free       = !rsp_valid_reg || rsp.ready;
    assign ptr_dec        = ptr_reg - CNT_W'(1);
    assign count_ext      = EXT_W'(count_reg);

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.count      = rsp_count_reg;
    assign rsp.smallest   = rsp_smallest_reg;
    assign rsp.empty_res  = rsp_empty_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.op == OP_INSERT && is_full)
                        state_next = ST_RESULT;
                    else
                        state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                if (op_reg == OP_INSERT)
                    state_next = ins_at_end ? ST_RESULT : ST_CMP;
                else
                    state_next = del_at_end ? ST_RESULT : ST_CMP;
            end
            ST_CMP:
            begin
                if (op_reg == OP_INSERT && !rd_greater)
                    state_next = ST_RESULT;
                else
                    state_next = ST_RD;
            end
            ST_RESULT:
            begin
                if (rsp_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        ptr_next          = ptr_reg;
        count_next        = count_reg;
        op_next           = op_reg;
        value_next        = value_reg;
        found_next        = found_reg;
        status_next       = status_reg;
        smallest_next     = smallest_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp.ready;
        rsp_status_next   = rsp_status_reg;
        rsp_count_next    = rsp_count_reg;
        rsp_smallest_next = rsp_smallest_reg;
        rsp_empty_next    = rsp_empty_reg;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        mem_waddr         = '0;
        mem_raddr         = '0;
        mem_wdata         = value_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    op_next     = req.op;
                    value_next  = req.value;
                    found_next  = 1'b0;
                    ptr_next    = (req.op == OP_INSERT) ? count_reg : '0;
                    status_next = (req.op == OP_INSERT && is_full) ? STAT_FULL : STAT_DONE;
                end
            end
            ST_RD:
            begin
                if (op_reg == OP_INSERT)
                begin
                    if (ins_at_end)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        mem_wdata  = value_reg;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = ptr_dec[AW-1:0];
                    end
                end
                else
                begin
                    if (del_at_end)
                    begin
                        if (found_reg)
                            count_next = count_reg - CNT_W'(1);
                        else
                            status_next = STAT_NOT_FOUND;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = ptr_reg[AW-1:0];
                    end
                end
            end
            ST_CMP:
            begin
                if (op_reg == OP_INSERT)
                begin
                    // hole at ptr: shift larger entry up, or drop value in
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg[AW-1:0];
                    if (rd_greater)
                    begin
                        mem_wdata = mem_rdata_reg;
                        ptr_next  = ptr_dec;
                    end
                    else
                    begin
                        mem_wdata  = value_reg;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    // after the match, every entry moves down one slot
                    if (found_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = ptr_dec[AW-1:0];
                        mem_wdata = mem_rdata_reg;
                    end
                    else if (rd_equal)
                        found_next = 1'b1;
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            ST_RESULT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_status_next   = status_reg;
                    rsp_count_next    = count_ext[STI_COUNT_W-1:0];
                    rsp_empty_next    = (count_reg == '0);
                    rsp_smallest_next = (count_reg == '0) ? '0 : smallest_reg;
                end
            end
            default: ;
        endcase

        // shadow copy of slot 0
        if (mem_we && mem_waddr == '0)
            smallest_next = mem_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg          <= ptr_next;
        op_reg           <= op_next;
        value_reg        <= value_next;
        found_reg        <= found_next;
        status_reg       <= status_next;
        smallest_reg     <= smallest_next;
        rsp_status_reg   <= rsp_status_next;
        rsp_count_reg    <= rsp_count_next;
        rsp_smallest_reg <= rsp_smallest_next;
        rsp_empty_reg    <= rsp_empty_next;
    end

    // table memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= mem[mem_raddr];
    end

endmodule

`default_nettype wire

[rtl/core/sti_checker.sv]
// Port-level checks for the sorted table top, bound to every instance.
// Depends on sti_pkg and sorted_table_insert_delete_top_assert.svh.
`default_nettype none
`include "sorted_table_insert_delete_top_assert.svh"

module sti_checker (
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  req_valid,
    input wire logic                                  req_ready,
    input wire logic                                  rsp_valid,
    input wire logic                                  rsp_ready,
    input wire logic [sti_pkg::STI_STATUS_W-1:0]      rsp_status,
    input wire logic [sti_pkg::STI_COUNT_W-1:0]       rsp_count,
    input wire logic signed [sti_pkg::STI_DATA_W-1:0] rsp_smallest,
    input wire logic                                  rsp_empty_res
);
    import sti_pkg::*;

    `STI_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_count) && $stable(rsp_smallest) && $stable(rsp_empty_res), "stalled result word changed")
    `STI_ASSERT(a_one_in_flight, req_valid && req_ready |=> !req_ready, "second word taken while busy")
    `STI_ASSERT(a_empty_flag, rsp_valid |-> (rsp_empty_res == (rsp_count == '0)), "empty flag disagrees with count")
    `STI_ASSERT(a_empty_smallest, rsp_valid && rsp_empty_res |-> (rsp_smallest == '0), "smallest not zero on empty table")
    `STI_ASSERT(a_full_nonempty, rsp_valid && rsp_status == STAT_FULL |-> !rsp_empty_res, "full status on empty table")

endmodule

bind sorted_table_insert_delete_top sti_checker u_sti_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_count    (rsp.count),
    .rsp_smallest (rsp.smallest),
    .rsp_empty_res(rsp.empty_res)
);

`default_nettype wire

[sim/tb_top.sv]
// Self-checking bench for the sorted table block: directed and random insert/delete words.
// Checks each result against an in-bench table predictor.
// Depends on sti_pkg, sti_req_if, sti_rsp_if and sorted_table_insert_delete_top.
`default_nettype none

module tb_top;
    import sti_pkg::*;

    localparam int unsigned CAP         = STI_CAPACITY;
    localparam int unsigned RAND_WORDS  = 550;
    localparam int unsigned HOLD_AT     = 150;
    localparam int unsigned HOLD_LEN    = 1500;
    localparam int unsigned TAIL_CYCLES = 200;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PRINT_CAP   = 30;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic              op;
        logic signed [31:0] value;
        int unsigned       gap;
        bit                drain;
    } req_word_t;

    typedef struct {
        logic [STI_STATUS_W-1:0] status;
        logic [STI_COUNT_W-1:0]  count;
        logic signed [31:0]      smallest;
        logic                    empty_res;
    } table_result_t;

    logic clk = 1'b0;
    logic rst_n;

    sti_req_if req_bus ();
    sti_rsp_if rsp_bus ();

    sorted_table_insert_delete_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    req_word_t          pending_words [$];
    table_result_t      expected_results [$];
    logic signed [31:0] shadow_tbl [$];
    int                 plan_tbl [$];
    bit                 quiet = 1'b0;

    int unsigned sent_cnt     = 0;
    int unsigned results_seen = 0;
    int unsigned error_cnt    = 0;
    int unsigned cycle_cnt    = 0;
    int unsigned n_insert     = 0;
    int unsigned n_delete     = 0;
    int unsigned n_full       = 0;
    int unsigned n_missing    = 0;
    int unsigned peak_fill    = 0;

    task automatic report_mismatch(input string msg);
        if (error_cnt < PRINT_CAP)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        error_cnt++;
    endtask

    // table predictor: ascending, duplicates after equals, delete removes first equal
    function automatic table_result_t apply_table_op(input logic op_i,
                                                     input logic signed [31:0] v);
        table_result_t r;
        int            pos;
        r.status = STAT_DONE;
        pos = 0;
        if (op_i == OP_INSERT) begin
            if (shadow_tbl.size() >= CAP) begin
                r.status = STAT_FULL;
            end else begin
                while (pos < shadow_tbl.size() && shadow_tbl[pos] <= v)
                    pos++;
                shadow_tbl.insert(pos, v);
            end
        end else begin
            while (pos < shadow_tbl.size() && shadow_tbl[pos] != v)
                pos++;
            if (pos < shadow_tbl.size())
                shadow_tbl.delete(pos);
            else
                r.status = STAT_NOT_FOUND;
        end
        r.count     = STI_COUNT_W'(shadow_tbl.size());
        r.empty_res = (shadow_tbl.size() == 0);
        r.smallest  = (shadow_tbl.size() == 0) ? 32'sd0 : shadow_tbl[0];
        return r;
    endfunction

    // stimulus planning keeps a multiset of what the table will hold
    task automatic queue_word(input logic op_i, input int v, input bit drain_i);
        req_word_t w;
        int        i;
        w.op    = op_i;
        w.value = v;
        w.gap   = quiet ? 0 : $urandom_range(0, 8);
        w.drain = drain_i;
        pending_words.push_back(w);
        if (op_i == OP_INSERT) begin
            if (plan_tbl.size() < CAP)
                plan_tbl.push_back(v);
        end else begin
            for (i = 0; i < plan_tbl.size(); i++) begin
                if (plan_tbl[i] == v) begin
                    plan_tbl.delete(i);
                    break;
                end
            end
        end
    endtask

    function automatic int pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return int'($urandom_range(0, 40)) - 20;
        else if (sel == 4)
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return 0;
                default: return -1;
            endcase
        else
            return int'($urandom);
    endfunction

    function automatic int pick_stored();
        return plan_tbl[$urandom_range(0, plan_tbl.size() - 1)];
    endfunction

    // driver
    logic        req_fire;
    int unsigned wait_n;
    int unsigned gap_left;
    int unsigned after_gap;
    req_word_t   cur_word;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_bus.valid <= 1'b0;
            req_bus.op    <= OP_INSERT;
            req_bus.value <= '0;
            gap_left      <= 0;
            after_gap     <= 0;
            sent_cnt      <= 0;
        end else if (!(req_bus.valid && !req_bus.ready)) begin
            req_fire = req_bus.valid && req_bus.ready;
            if (req_fire)
                sent_cnt <= sent_cnt + 1;
            wait_n = req_fire ? after_gap : gap_left;
            if (wait_n != 0) begin
                gap_left      <= wait_n - 1;
                req_bus.valid <= 1'b0;
            end else if (pending_words.size() != 0 &&
                         !(pending_words[0].drain &&
                           (sent_cnt + req_fire) != results_seen)) begin
                cur_word       = pending_words.pop_front();
                req_bus.valid <= 1'b1;
                req_bus.op    <= cur_word.op;
                req_bus.value <= cur_word.value;
                after_gap     <= cur_word.gap;
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // receiver: per-word stall, one long hold-off
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned rsp_wait;
    bit          hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= 0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_LEN;
            rsp_bus.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= (hold_left == 1);
        end else if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_wait = (results_seen >= 300 && results_seen < 360) ? 0 : $urandom_range(0, 8);
            stall_left    <= rsp_wait;
            rsp_bus.ready <= (rsp_wait == 0);
        end else if (stall_left != 0) begin
            if (rsp_bus.valid)
                stall_left <= stall_left - 1;
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= 1'b1;
        end
    end

    // monitor: predict on request, compare on response
    table_result_t want;

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (req_bus.valid && req_bus.ready) begin
                want = apply_table_op(req_bus.op, req_bus.value);
                expected_results.push_back(want);
                if (req_bus.op == OP_INSERT)
                    n_insert++;
                else
                    n_delete++;
                if (want.status == STAT_FULL)
                    n_full++;
                if (want.status == STAT_NOT_FOUND)
                    n_missing++;
                if (want.count > peak_fill)
                    peak_fill = want.count;
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    report_mismatch("result word with nothing outstanding");
                end else begin
                    want = expected_results.pop_front();
                    if (rsp_bus.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp_bus.status, want.status));
                    if (rsp_bus.count !== want.count)
                        report_mismatch($sformatf("count %0d, expected %0d",
                                                  rsp_bus.count, want.count));
                    if (rsp_bus.smallest !== want.smallest)
                        report_mismatch($sformatf("smallest %0d, expected %0d",
                                                  rsp_bus.smallest, want.smallest));
                    if (rsp_bus.empty_res !== want.empty_res)
                        report_mismatch($sformatf("empty_res %0b, expected %0b",
                                                  rsp_bus.empty_res, want.empty_res));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words outstanding",
                     cycle_cnt, expected_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    int unsigned n_rand;
    int unsigned phase_idx;
    int unsigned kind;
    int unsigned k;

    initial
    begin
        rst_n = 1'b0;

        // directed: empty, single entry, extremes, duplicates, misses
        queue_word(OP_DELETE, 0, 1'b0);
        queue_word(OP_INSERT, VAL_MIN, 1'b0);
        queue_word(OP_DELETE, 5, 1'b0);
        queue_word(OP_DELETE, VAL_MIN, 1'b0);
        queue_word(OP_INSERT, VAL_MAX, 1'b0);
        queue_word(OP_INSERT, VAL_MIN, 1'b0);
        queue_word(OP_INSERT, 0, 1'b0);
        queue_word(OP_INSERT, -1, 1'b0);
        queue_word(OP_INSERT, 0, 1'b0);
        queue_word(OP_INSERT, VAL_MAX, 1'b0);
        queue_word(OP_INSERT, 1, 1'b0);
        queue_word(OP_DELETE, 0, 1'b0);
        queue_word(OP_DELETE, 0, 1'b0);
        queue_word(OP_DELETE, 0, 1'b0);
        queue_word(OP_DELETE, VAL_MAX, 1'b0);
        queue_word(OP_DELETE, VAL_MIN, 1'b0);
        queue_word(OP_DELETE, -1, 1'b0);
        queue_word(OP_DELETE, 7, 1'b0);
        queue_word(OP_DELETE, 1, 1'b0);
        queue_word(OP_DELETE, VAL_MAX, 1'b0);

        // random phases: fill to full, drain to empty, mixed traffic
        n_rand = 0;
        phase_idx = 0;
        while (n_rand < RAND_WORDS) begin
            kind  = (phase_idx < 2) ? phase_idx : $urandom_range(0, 3);
            quiet = ($urandom_range(0, 3) == 0);
            case (kind)
                0: begin
                    queue_word(OP_INSERT, pick_value(), 1'b1);
                    n_rand++;
                    while (plan_tbl.size() < CAP) begin
                        queue_word(OP_INSERT, pick_value(), 1'b0);
                        n_rand++;
                    end
                    repeat ($urandom_range(1, 4)) begin
                        queue_word(OP_INSERT, pick_value(), 1'b0);
                        n_rand++;
                    end
                end
                1: begin
                    queue_word(OP_DELETE, pick_value(), 1'b1);
                    n_rand++;
                    while (plan_tbl.size() != 0) begin
                        queue_word(OP_DELETE, pick_stored(), 1'b0);
                        n_rand++;
                    end
                    repeat ($urandom_range(1, 3)) begin
                        queue_word(OP_DELETE, pick_value(), 1'b0);
                        n_rand++;
                    end
                end
                default: begin
                    for (k = 0; k < 25; k++) begin
                        if ($urandom_range(0, 1) == 0 || plan_tbl.size() == 0)
                            queue_word($urandom_range(0, 4) == 0 ? OP_DELETE : OP_INSERT,
                                       pick_value(), k == 0);
                        else if ($urandom_range(0, 3) != 0)
                            queue_word(OP_DELETE, pick_stored(), k == 0);
                        else
                            queue_word(OP_DELETE, pick_value(), k == 0);
                        n_rand++;
                    end
                end
            endcase
            phase_idx++;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0)
            @(posedge clk);
        while (req_bus.valid || sent_cnt != results_seen || expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));

        $display("Ran %0d inserts (%0d hit a full table) and %0d deletes (%0d found nothing).",
                 n_insert, n_full, n_delete, n_missing);
        $display("Peak fill %0d of %0d entries, %0d phases, %0d mismatches.",
                 peak_fill, CAP, phase_idx, error_cnt);
        if (error_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl/core
rtl/core/sti_pkg.sv
rtl/core/sti_req_if.sv
rtl/core/sti_rsp_if.sv
rtl/core/sorted_table_insert_delete_top.sv
rtl/core/sti_checker.sv
sim/tb_top.sv
